>>> src/pbra_pkg.sv
// Shared types and constants for the page bitmap run allocator.
// Used by pbra_page_walk and page_bitmap_run_allocator.
`default_nettype none
package pbra_pkg;

	// default geometry, handed to the top level parameters
	localparam int unsigned PAGE_BYTES_DEF = 4096;
	localparam int unsigned PAGE_COUNT_DEF = 64;

	// field widths
	localparam int unsigned ADDR_W   = 32;
	localparam int unsigned RBYTES_W = 19;
	localparam int unsigned STATUS_W = 3;

	// serial divider numerator/quotient width and its step counter
	localparam int unsigned NUM_W   = 33;
	localparam int unsigned DCNT_W  = $clog2(NUM_W);

	// APB port
	localparam int unsigned APB_ADDR_W = 3;
	localparam int unsigned APB_DATA_W = 32;
	localparam logic REG_BASE_IDX  = 1'b0;
	localparam logic REG_BYTES_IDX = 1'b1;

	// reset values of the config registers
	localparam logic [ADDR_W-1:0]   BASE_RST   = 32'd4096;
	localparam logic [RBYTES_W-1:0] RBYTES_RST = 19'd262144;

	// commands
	localparam logic CMD_ALLOC = 1'b0;
	localparam logic CMD_FREE  = 1'b1;

	// result status codes
	localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
	localparam logic [STATUS_W-1:0] ST_TOO_BIG  = 3'd1;
	localparam logic [STATUS_W-1:0] ST_NO_RUN   = 3'd2;
	localparam logic [STATUS_W-1:0] ST_NOT_BUSY = 3'd3;
	localparam logic [STATUS_W-1:0] ST_NO_ALLOC = 3'd4;

	// bitmap walk pass kinds
	localparam logic [1:0] PASS_SCAN  = 2'd0;
	localparam logic [1:0] PASS_CHECK = 2'd1;
	localparam logic [1:0] PASS_WRITE = 2'd2;

	typedef struct packed {
		logic                cmd;
		logic [ADDR_W-1:0]   request_bytes;
		logic [ADDR_W-1:0]   free_addr;
	} req_beat_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [ADDR_W-1:0]   granted_addr;
	} rsp_beat_t;

	// control from the sequencer to the bitmap walker
	typedef struct packed {
		logic       init;
		logic       step;
		logic [1:0] mode;
		logic       set_val;
	} walk_ctl_t;

	// status from the bitmap walker
	typedef struct packed {
		logic found;
		logic all_busy;
		logic last;
	} walk_res_t;

endpackage
`default_nettype wire

>>> src/pbra_ser_div.sv
// Bit-serial restoring divider by a constant, one quotient bit per step.
// Uses pbra_pkg for nothing; standalone leaf.
`default_nettype none
module pbra_ser_div #(
	parameter int unsigned DIVISOR = 4096,
	parameter int unsigned NUM_W   = 33
) (
	input  wire logic             clk,
	input  wire logic             load,
	input  wire logic             step,
	input  wire logic [NUM_W-1:0] num,
	output logic      [NUM_W-1:0] quot
);

	localparam int unsigned RW = $clog2(DIVISOR) + 1;
	localparam logic [RW-1:0] DIV_R = RW'(DIVISOR);

	logic [NUM_W-1:0] sh_q;
	logic [RW-1:0]    rem_q;
	logic [RW-1:0]    trial;
	logic             ge;

	// shift next numerator bit into the partial remainder
	assign trial = {rem_q[RW-2:0], sh_q[NUM_W-1]};
	assign ge    = trial >= DIV_R;

	always_ff @(posedge clk) begin
		if (load) begin
			sh_q  <= num;
			rem_q <= '0;
		end else if (step) begin
			rem_q <= ge ? (trial - DIV_R) : trial;
			sh_q  <= {sh_q[NUM_W-2:0], ge};
		end
	end

	assign quot = sh_q;

endmodule
`default_nettype wire

>>> src/pbra_page_walk.sv
// Busy-page map held as a rotating shift register, one page per cycle while step is high.
// Finds first free runs, checks runs busy and sets/clears runs. Uses pbra_pkg.
`default_nettype none
module pbra_page_walk #(
	parameter int unsigned PAGE_BYTES = pbra_pkg::PAGE_BYTES_DEF,
	parameter int unsigned PAGE_COUNT = pbra_pkg::PAGE_COUNT_DEF,
	localparam int unsigned IW = $clog2(PAGE_COUNT),
	localparam int unsigned CW = $clog2(PAGE_COUNT + 1)
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire pbra_pkg::walk_ctl_t           ctl,
	input  wire logic [pbra_pkg::ADDR_W-1:0]   base,
	input  wire logic [IW-1:0]                 win_start,
	input  wire logic [CW-1:0]                 win_len,
	input  wire logic [CW-1:0]                 limit,
	output pbra_pkg::walk_res_t                res,
	output logic      [IW-1:0]                 found_start,
	output logic      [pbra_pkg::ADDR_W-1:0]   found_addr
);

	localparam logic [IW-1:0] LAST = IW'(PAGE_COUNT - 1);
	localparam logic [pbra_pkg::ADDR_W-1:0] PB_W = pbra_pkg::ADDR_W'(PAGE_BYTES);

	logic [PAGE_COUNT-1:0]         map_q;
	logic [IW-1:0]                 idx_q;
	logic [CW-1:0]                 run_q;
	logic [CW-1:0]                 cand_q;
	logic                          found_q;
	logic                          busy_ok_q;
	logic [IW-1:0]                 start_q;
	logic [pbra_pkg::ADDR_W-1:0]   page_addr_q;
	logic [pbra_pkg::ADDR_W-1:0]   cand_addr_q;
	logic [pbra_pkg::ADDR_W-1:0]   found_addr_q;

	logic          cur;
	logic [CW-1:0] idx_w;
	logic [CW-1:0] off;
	logic          in_lim;
	logic          in_win;
	logic          is_free;
	logic [CW-1:0] run_nxt;
	logic          hit;
	logic          new_bit;

	// page under the head of the map and its window membership
	assign cur     = map_q[0];
	assign idx_w   = CW'(idx_q);
	assign off     = idx_w - CW'(win_start);
	assign in_lim  = idx_w < limit;
	assign in_win  = in_lim && (idx_q >= win_start) && (off < win_len);

	// free-run tracking for the first-fit search
	assign is_free = in_lim && !cur;
	assign run_nxt = is_free ? (run_q + CW'(1)) : '0;
	assign hit     = (ctl.mode == pbra_pkg::PASS_SCAN) && is_free && !found_q
		&& (run_nxt == win_len);

	// bit written back at the tail of the rotation
	assign new_bit = ((ctl.mode == pbra_pkg::PASS_WRITE) && in_win) ? ctl.set_val : cur;

	// map and walk control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			map_q     <= '0;
			idx_q     <= '0;
			run_q     <= '0;
			cand_q    <= '0;
			found_q   <= 1'b0;
			busy_ok_q <= 1'b1;
		end else if (ctl.init) begin
			idx_q     <= '0;
			run_q     <= '0;
			cand_q    <= '0;
			found_q   <= 1'b0;
			busy_ok_q <= 1'b1;
		end else if (ctl.step) begin
			map_q <= {new_bit, map_q[PAGE_COUNT-1:1]};
			idx_q <= (idx_q == LAST) ? '0 : (idx_q + IW'(1));
			if (ctl.mode == pbra_pkg::PASS_SCAN) begin
				run_q <= run_nxt;
				if (!is_free)
					cand_q <= idx_w + CW'(1);
				if (hit)
					found_q <= 1'b1;
			end
			if ((ctl.mode == pbra_pkg::PASS_CHECK) && in_win && !cur)
				busy_ok_q <= 1'b0;
		end
	end

	// address tracking of the current page and the run candidate
	always_ff @(posedge clk) begin
		if (ctl.init) begin
			page_addr_q <= base;
			cand_addr_q <= base;
		end else if (ctl.step) begin
			page_addr_q <= page_addr_q + PB_W;
			if ((ctl.mode == pbra_pkg::PASS_SCAN) && !is_free)
				cand_addr_q <= page_addr_q + PB_W;
			if (hit) begin
				start_q      <= cand_q[IW-1:0];
				found_addr_q <= cand_addr_q;
			end
		end
	end

	assign res.found    = found_q;
	assign res.all_busy = busy_ok_q;
	assign res.last     = ctl.step && (idx_q == LAST);
	assign found_start  = start_q;
	assign found_addr   = found_addr_q;

endmodule
`default_nettype wire

>>> src/page_bitmap_run_allocator.sv
// First-fit page run allocator over a 64-page busy map, APB configured.
// Early rejects and zero-page beats go from the serial division straight to the finish state;
// a failed search or busy check adds one map pass, and a run that is set or cleared adds a
// second, writing pass; the 33-step serial divider and bit-serial map passes do the work.
// One beat in flight; the next is accepted in the idle state, entered as the result is loaded.
// Reset clears the busy map and the alloc-seen flag and loads base 4096, size 262144.
`default_nettype none
module page_bitmap_run_allocator #(
	parameter int unsigned PAGE_BYTES = pbra_pkg::PAGE_BYTES_DEF,
	parameter int unsigned PAGE_COUNT = pbra_pkg::PAGE_COUNT_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              req_valid,
	output logic                                   req_stall,
	input  wire pbra_pkg::req_beat_t               req_beat,
	output logic                                   rsp_valid,
	input  wire logic                              rsp_stall,
	output pbra_pkg::rsp_beat_t                    rsp_beat,
	input  wire logic                              psel,
	input  wire logic                              penable,
	input  wire logic                              pwrite,
	input  wire logic [pbra_pkg::APB_ADDR_W-1:0]   paddr,
	input  wire logic [pbra_pkg::APB_DATA_W-1:0]   pwdata,
	output logic      [pbra_pkg::APB_DATA_W-1:0]   prdata,
	output logic                                   pready
);

	localparam int unsigned IW = $clog2(PAGE_COUNT);
	localparam int unsigned CW = $clog2(PAGE_COUNT + 1);
	localparam int unsigned EW = CW + 1;
	localparam int unsigned NW = pbra_pkg::NUM_W;
	localparam int unsigned AW = pbra_pkg::ADDR_W;

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_DIV    = 3'd1;
	localparam logic [2:0] ST_DECIDE = 3'd2;
	localparam logic [2:0] ST_SCAN   = 3'd3;
	localparam logic [2:0] ST_EVAL   = 3'd4;
	localparam logic [2:0] ST_WRITE  = 3'd5;
	localparam logic [2:0] ST_FIN    = 3'd6;

	localparam logic [pbra_pkg::DCNT_W-1:0] DCNT_LAST = pbra_pkg::DCNT_W'(NW - 1);

	logic [2:0]                      state_q;
	logic [AW-1:0]                   base_q;
	logic [pbra_pkg::RBYTES_W-1:0]   rbytes_q;
	logic                            seen_q;
	logic                            cmd_q;
	logic                            below_q;
	logic [pbra_pkg::DCNT_W-1:0]     dcnt_q;
	logic [1:0]                      mode_q;
	logic [IW-1:0]                   win_start_q;
	logic [CW-1:0]                   n_q;
	logic [CW-1:0]                   lim_q;
	logic [pbra_pkg::STATUS_W-1:0]   status_q;
	logic [AW-1:0]                   gaddr_q;
	logic                            rsp_valid_q;
	pbra_pkg::rsp_beat_t             rsp_q;

	logic                accept;
	logic                cfg_wr;
	logic                div_load;
	logic                div_step;
	logic [NW-1:0]       num_n;
	logic [NW-1:0]       num_f;
	logic [NW-1:0]       num_p;
	logic [NW-1:0]       q_n;
	logic [NW-1:0]       q_f;
	logic [NW-1:0]       q_p;

	pbra_pkg::walk_ctl_t wctl;
	pbra_pkg::walk_res_t wres;
	logic [IW-1:0]       found_start;
	logic [AW-1:0]       found_addr;

	logic [CW-1:0]                 lim;
	logic                          too_big;
	logic                          n_zero;
	logic                          n_fits;
	logic                          first_in;
	logic                          end_out;
	logic                          dec_walk;
	logic [1:0]                    dec_mode;
	logic [pbra_pkg::STATUS_W-1:0] dec_status;
	logic [AW-1:0]                 dec_addr;
	logic                          ev_write;
	logic [pbra_pkg::STATUS_W-1:0] ev_status;
	logic [AW-1:0]                 ev_addr;
	logic                          rsp_load;

	// handshakes
	assign accept    = req_valid && !req_stall;
	assign req_stall = state_q != ST_IDLE;
	assign rsp_load  = (state_q == ST_FIN) && (!rsp_valid_q || !rsp_stall);
	assign rsp_valid = rsp_valid_q;
	assign rsp_beat  = rsp_q;

	// APB register file
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_comb begin
		case (paddr[2])
			pbra_pkg::REG_BASE_IDX:  prdata = base_q;
			pbra_pkg::REG_BYTES_IDX: prdata = pbra_pkg::APB_DATA_W'(rbytes_q);
			default:                 prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q   <= pbra_pkg::BASE_RST;
			rbytes_q <= pbra_pkg::RBYTES_RST;
		end else if (cfg_wr) begin
			case (paddr[2])
				pbra_pkg::REG_BASE_IDX:  base_q   <= pwdata;
				pbra_pkg::REG_BYTES_IDX: rbytes_q <= pwdata[pbra_pkg::RBYTES_W-1:0];
				default:                 base_q   <= base_q;
			endcase
		end
	end

	// serial dividers: page count, start page of a free, usable pages
	assign num_n    = NW'(req_beat.request_bytes) + NW'(PAGE_BYTES - 1);
	assign num_f    = NW'(req_beat.free_addr) - NW'(base_q);
	assign num_p    = NW'(rbytes_q);
	assign div_load = accept;
	assign div_step = state_q == ST_DIV;

	pbra_ser_div #(.DIVISOR(PAGE_BYTES), .NUM_W(NW)) u_div_n (
		.clk(clk), .load(div_load), .step(div_step), .num(num_n), .quot(q_n)
	);
	pbra_ser_div #(.DIVISOR(PAGE_BYTES), .NUM_W(NW)) u_div_f (
		.clk(clk), .load(div_load), .step(div_step), .num(num_f), .quot(q_f)
	);
	pbra_ser_div #(.DIVISOR(PAGE_BYTES), .NUM_W(NW)) u_div_p (
		.clk(clk), .load(div_load), .step(div_step), .num(num_p), .quot(q_p)
	);

	// range checks once the quotients are in
	assign lim      = (q_p < NW'(PAGE_COUNT)) ? CW'(q_p) : CW'(PAGE_COUNT);
	assign too_big  = q_n > q_p;
	assign n_zero   = q_n == '0;
	assign n_fits   = q_n <= NW'(lim);
	assign first_in = q_f < NW'(lim);
	assign end_out  = (EW'(q_f[CW-1:0]) + EW'(q_n[CW-1:0])) > EW'(lim);

	always_comb begin
		dec_walk   = 1'b0;
		dec_mode   = pbra_pkg::PASS_SCAN;
		dec_status = pbra_pkg::ST_OK;
		dec_addr   = '0;
		if (cmd_q == pbra_pkg::CMD_ALLOC) begin
			if (too_big)
				dec_status = pbra_pkg::ST_TOO_BIG;
			else if (n_zero)
				dec_addr = base_q;
			else if (!n_fits)
				dec_status = pbra_pkg::ST_NO_RUN;
			else
				dec_walk = 1'b1;
		end else begin
			dec_mode = pbra_pkg::PASS_CHECK;
			if (!seen_q)
				dec_status = pbra_pkg::ST_NO_ALLOC;
			else if (too_big)
				dec_status = pbra_pkg::ST_TOO_BIG;
			else if (below_q)
				dec_status = pbra_pkg::ST_NOT_BUSY;
			else if (n_zero)
				dec_status = pbra_pkg::ST_OK;
			else if (!n_fits || !first_in || end_out)
				dec_status = pbra_pkg::ST_NOT_BUSY;
			else
				dec_walk = 1'b1;
		end
	end

	// outcome of the search or busy check
	always_comb begin
		ev_write  = 1'b0;
		ev_status = pbra_pkg::ST_OK;
		ev_addr   = '0;
		if (cmd_q == pbra_pkg::CMD_ALLOC) begin
			if (wres.found) begin
				ev_write = 1'b1;
				ev_addr  = found_addr;
			end else begin
				ev_status = pbra_pkg::ST_NO_RUN;
			end
		end else begin
			if (wres.all_busy)
				ev_write = 1'b1;
			else
				ev_status = pbra_pkg::ST_NOT_BUSY;
		end
	end

	// bitmap walker control
	assign wctl.init    = ((state_q == ST_DECIDE) && dec_walk) || ((state_q == ST_EVAL) && ev_write);
	assign wctl.step    = (state_q == ST_SCAN) || (state_q == ST_WRITE);
	assign wctl.mode    = mode_q;
	assign wctl.set_val = cmd_q == pbra_pkg::CMD_ALLOC;

	pbra_page_walk #(.PAGE_BYTES(PAGE_BYTES), .PAGE_COUNT(PAGE_COUNT)) u_walk (
		.clk(clk), .arst_n(arst_n), .ctl(wctl), .base(base_q),
		.win_start(win_start_q), .win_len(n_q), .limit(lim_q),
		.res(wres), .found_start(found_start), .found_addr(found_addr)
	);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			seen_q      <= 1'b0;
			cmd_q       <= pbra_pkg::CMD_ALLOC;
			below_q     <= 1'b0;
			dcnt_q      <= '0;
			mode_q      <= pbra_pkg::PASS_SCAN;
			win_start_q <= '0;
			n_q         <= '0;
			lim_q       <= '0;
			status_q    <= pbra_pkg::ST_OK;
			gaddr_q     <= '0;
			rsp_valid_q <= 1'b0;
			rsp_q       <= '0;
		end else begin
			if (rsp_load) begin
				rsp_valid_q        <= 1'b1;
				rsp_q.status       <= status_q;
				rsp_q.granted_addr <= gaddr_q;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						cmd_q   <= req_beat.cmd;
						below_q <= req_beat.free_addr < base_q;
						dcnt_q  <= '0;
						if (req_beat.cmd == pbra_pkg::CMD_ALLOC)
							seen_q <= 1'b1;
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					dcnt_q <= dcnt_q + pbra_pkg::DCNT_W'(1);
					if (dcnt_q == DCNT_LAST)
						state_q <= ST_DECIDE;
				end
				ST_DECIDE: begin
					status_q    <= dec_status;
					gaddr_q     <= dec_addr;
					mode_q      <= dec_mode;
					n_q         <= q_n[CW-1:0];
					lim_q       <= lim;
					win_start_q <= q_f[IW-1:0];
					state_q     <= dec_walk ? ST_SCAN : ST_FIN;
				end
				ST_SCAN: begin
					if (wres.last)
						state_q <= ST_EVAL;
				end
				ST_EVAL: begin
					status_q <= ev_status;
					gaddr_q  <= ev_addr;
					mode_q   <= pbra_pkg::PASS_WRITE;
					if (cmd_q == pbra_pkg::CMD_ALLOC)
						win_start_q <= found_start;
					state_q  <= ev_write ? ST_WRITE : ST_FIN;
				end
				ST_WRITE: begin
					if (wres.last)
						state_q <= ST_FIN;
				end
				ST_FIN: begin
					if (rsp_load)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

`ifndef SYNTHESIS
	// a failed beat never carries an address
	a_fail_no_addr: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp_beat.status != pbra_pkg::ST_OK) |-> rsp_beat.granted_addr == '0)
		else $error("nonzero address on failed beat");

	// the alloc-seen flag never drops once set
	a_seen_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		seen_q |=> seen_q)
		else $error("alloc-seen flag cleared");

	// a new result only appears out of the finish state
	a_rsp_from_fin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) |-> $past(state_q) == ST_FIN)
		else $error("result raised outside finish");

	// map writes follow a successful search or check
	a_write_mode: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WRITE) |-> (mode_q == pbra_pkg::PASS_WRITE) && (status_q == pbra_pkg::ST_OK))
		else $error("map write without success");
`endif

endmodule
`default_nettype wire
